// File: sv/tdpc_pkg.sv
// Shared types and constants for the trial-division prime counter.
package tdpc_pkg;

  // Remainder bits retired per cycle by the divider
  localparam int RADIX_BITS = 4;

  localparam logic [31:0] TALLY_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic load;       // capture candidate, divisor := 2
    logic div_start;  // clear remainder, reload shift copy
    logic div_step;   // retire RADIX_BITS remainder bits
    logic next_div;   // advance to next divisor and its square
    logic publish;    // write result register
    logic verdict;    // prime flag to publish
  } tdpc_cmd_t;

  typedef struct packed {
    logic below_two;  // candidate below 2
    logic past_root;  // divisor squared exceeds candidate
    logic div_last;   // final remainder group this cycle
    logic rem_zero;   // divisor divides candidate
    logic out_free;   // result register can take a new result
  } tdpc_status_t;

endpackage

// File: sv/tdpc_datapath.sv
// Datapath: candidate, divisor and square, shift-subtract remainder unit, result register.
module tdpc_datapath
  import tdpc_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [31:0]  candidate_i,
  input  tdpc_cmd_t    cmd_i,
  output tdpc_status_t status_o,
  input  logic         out_stall_i,
  output logic         out_valid_o,
  output logic         is_prime_o,
  output logic [31:0]  prime_total_o
);

  localparam int VW     = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int DW     = VW / 2 + 2;
  localparam int SW     = 2 * DW;
  localparam int GROUPS = (VW + RADIX_BITS - 1) / RADIX_BITS;
  localparam int PW     = GROUPS * RADIX_BITS;
  localparam int CW     = $clog2(GROUPS);

  logic [VW-1:0] v_q;
  logic [DW-1:0] d_q;
  logic [SW-1:0] sq_q;
  logic [DW-1:0] rem_q, rem_d;
  logic [PW-1:0] vs_q;
  logic [CW-1:0] cnt_q;
  logic          out_valid_q;
  logic          is_prime_q;
  logic [31:0]   tally_q;

  // RADIX_BITS restoring steps on the remainder
  always_comb begin
    logic [DW:0]   trial;
    logic [DW-1:0] r;
    r     = rem_q;
    trial = '0;
    for (int k = 0; k < RADIX_BITS; k++) begin
      trial = {r, vs_q[PW-1-k]};
      if (trial >= {1'b0, d_q}) begin
        r = DW'(trial - {1'b0, d_q});
      end else begin
        r = trial[DW-1:0];
      end
    end
    rem_d = r;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      v_q  <= candidate_i[VW-1:0];
      d_q  <= DW'(2);
      sq_q <= SW'(4);
    end else if (cmd_i.next_div) begin
      // 2 -> 3, then odd divisors only
      if (d_q == DW'(2)) begin
        d_q  <= DW'(3);
        sq_q <= sq_q + SW'(5);
      end else begin
        d_q  <= d_q + DW'(2);
        sq_q <= sq_q + SW'({d_q, 2'b00}) + SW'(4);
      end
    end
    if (cmd_i.div_start) begin
      rem_q <= '0;
      vs_q  <= PW'(v_q);
      cnt_q <= CW'(GROUPS - 1);
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      vs_q  <= vs_q << RADIX_BITS;
      cnt_q <= cnt_q - CW'(1);
    end
    if (cmd_i.publish) begin
      is_prime_q <= cmd_i.verdict;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      tally_q     <= '0;
    end else begin
      if (cmd_i.publish) begin
        out_valid_q <= 1'b1;
        if (cmd_i.verdict && tally_q != TALLY_MAX) begin
          tally_q <= tally_q + 32'd1;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.below_two = v_q < VW'(2);
  assign status_o.past_root = sq_q > SW'(v_q);
  assign status_o.div_last  = cnt_q == '0;
  assign status_o.rem_zero  = rem_q == '0;
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign is_prime_o    = is_prime_q;
  assign prime_total_o = tally_q;

endmodule

// File: sv/tdpc_controller.sv
// Controller: sequences bound check, remainder passes and result hand-off.
module tdpc_controller
  import tdpc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  tdpc_status_t status_i,
  output tdpc_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_TEST  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       verdict_q, verdict_d;

  always_comb begin
    state_d   = state_q;
    verdict_d = verdict_q;
    cmd_o     = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status_i.below_two) begin
          verdict_d = 1'b0;
          state_d   = S_DONE;
        end else if (status_i.past_root) begin
          verdict_d = 1'b1;
          state_d   = S_DONE;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = S_TEST;
        end
      end
      S_TEST: begin
        if (status_i.rem_zero) begin
          verdict_d = 1'b0;
          state_d   = S_DONE;
        end else begin
          cmd_o.next_div = 1'b1;
          state_d        = S_CHECK;
        end
      end
      S_DONE: begin
        cmd_o.verdict = verdict_q;
        if (status_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      verdict_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      verdict_q <= verdict_d;
    end
  end

  assign in_stall_o = state_q != S_IDLE;

endmodule

// File: sv/trial_division_prime_counter_unit.sv
// Top level of the trial-division prime counter.
//
// Input channel: in_valid_i / in_stall_o with candidate_i. One request is
// worked on at a time; in_stall_o is low only while the unit is idle.
// Output channel: out_valid_o / out_stall_i with is_prime_o and
// prime_total_o, one result per request, held in an output register so the
// next request is taken while a result still waits.
// Sequence: candidates below 4 go from the bound check straight to the
// result hand-off. Every divisor tried (2, then odd ones while
// d*d <= candidate) takes one bound check, the remainder passes of the
// shift-subtract divider (4 bits a cycle) and one remainder test.
// A 32-bit prime near the top of the range takes about 32768 divisors;
// the divider loop dominates its run time.
// Throughput: the next request is taken the cycle after the result is written.
// Reset clears the prime count to zero and empties the output register.
// A stalled result stays on the output; a finished request then waits in
// the controller until the register frees, and input stays stalled.
module trial_division_prime_counter_unit
  import tdpc_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] candidate_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        is_prime_o,
  output logic [31:0] prime_total_o
);

  tdpc_cmd_t    cmd;
  tdpc_status_t status;

  // sequencing
  tdpc_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // divisor, square bound, remainder and result/tally registers
  tdpc_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .candidate_i   (candidate_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .is_prime_o    (is_prime_o),
    .prime_total_o (prime_total_o)
  );

endmodule

// File: sv/tdpc_checker.sv
// Port-level checks for the prime counter, bound to the top level.
module tdpc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        is_prime_o,
  input logic [31:0] prime_total_o
);

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(is_prime_o) && $stable(prime_total_o))
    else $error("stalled result changed");

  a_total_steps_by_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prime_total_o != $past(prime_total_o) |-> prime_total_o == $past(prime_total_o) + 32'd1)
    else $error("prime count moved by other than one");

  a_total_only_on_prime: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && prime_total_o != $past(prime_total_o) |-> is_prime_o)
    else $error("prime count rose on a non-prime result");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken while one is in progress");

endmodule

bind trial_division_prime_counter_unit tdpc_checker u_tdpc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .is_prime_o    (is_prime_o),
  .prime_total_o (prime_total_o)
);

// File: dv/tb_top.sv
// Self-checking testbench for the trial-division prime counter unit.
module tb_top
  import tdpc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // Must match the unit's VALUE_BITS parameter (left at its default below)
  localparam int VALUE_BITS    = 32;
  localparam int IDLE_PCT      = 28;
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_STEADY = 30;
  localparam int RANDOM_MIXED  = 50;

  // Divisors used to build wide candidates that the unit rejects quickly
  localparam int unsigned CHEAP_FACTORS [6] = '{2, 3, 5, 7, 11, 13};

  typedef struct packed {
    logic [31:0] candidate;
    logic        is_prime;
    logic [31:0] prime_total;
  } prime_verdict_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [31:0] candidate_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        is_prime_o;
  logic [31:0] prime_total_o;

  // Shadow of the unit's prime count, advanced once per accepted prime, holding at full
  logic [31:0]    model_tally;
  // Verdicts still owed by the unit, oldest first
  prime_verdict_t pending_verdicts [$];

  bit          idle_en;
  int unsigned sent_count;
  int unsigned error_count;
  logic [31:0] largest_candidate;

  trial_division_prime_counter_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .candidate_i  (candidate_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .is_prime_o   (is_prime_o),
    .prime_total_o(prime_total_o)
  );

  always #5 clk_i = ~clk_i;

  // Hard stop. The slowest legal run is dominated by the largest 32-bit
  // prime; everything else is kept cheap.
  initial begin
    #40_000_000;
    $display("tb: failure");
    $finish;
  end

  // Plain trial division over every divisor from 2; the unit skips even
  // divisors above 2 but must reach the same verdict.
  function automatic logic check_primality(logic [31:0] value);
    longint unsigned v;
    longint unsigned d;
    v = 64'(value) & (((64'd1 << (VALUE_BITS - 1)) << 1) - 64'd1);
    if (v < 2) return 1'b0;
    for (d = 2; d <= v / d; d++) begin
      if (v % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Verdict for one request; bumps the shadow count on a prime, and the count sticks at full.
  function automatic prime_verdict_t predict_verdict(logic [31:0] value);
    prime_verdict_t verdict;
    verdict.candidate = value;
    verdict.is_prime  = check_primality(value);
    if (verdict.is_prime && model_tally != TALLY_MAX) model_tally++;
    verdict.prime_total = model_tally;
    return verdict;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] cand,
                                 logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: candidate %0d got %0d want %0d at %0t",
             what, cand, got, want, $realtime);
    error_count++;
  endtask

  // Drives one request and waits for the handshake. Valid is left high on
  // return so back-to-back requests never drop it within one time step.
  task automatic send_candidate(logic [31:0] value);
    int gap;
    gap = 0;
    if (idle_en && $urandom_range(0, 99) < IDLE_PCT) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid_i  <= 1'b0;
      candidate_i <= $urandom;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    candidate_i <= value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_verdicts.push_back(predict_verdict(value));
    sent_count++;
    if (value > largest_candidate) largest_candidate = value;
  endtask

  // Drops valid and holds off until every owed verdict has come back.
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_verdicts.size() != 0);
  endtask

  // Mostly small values that walk the whole divisor loop; the rest are
  // full-width values with a small factor so they finish early.
  function automatic logic [31:0] pick_candidate();
    int unsigned sel;
    int unsigned factor;
    logic [31:0] value;
    sel = $urandom_range(0, 99);
    if (sel < 20) begin
      value = $urandom_range(0, 300);
    end else if (sel < 70) begin
      value = $urandom_range(0, 65535);
    end else begin
      factor = CHEAP_FACTORS[$urandom_range(0, 5)];
      value  = $urandom;
      value  = value - (value % factor);
    end
    return value;
  endfunction

  // Result side: check every accepted result, then pick next cycle's stall.
  always @(posedge clk_i) begin : check_result
    prime_verdict_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("result with nothing owed", 32'd0, prime_total_o, 32'd0);
      end else begin
        want = pending_verdicts.pop_front();
        if (is_prime_o !== want.is_prime)
          report_mismatch("is_prime", want.candidate, 32'(is_prime_o),
                          32'(want.is_prime));
        if (prime_total_o !== want.prime_total)
          report_mismatch("prime_total", want.candidate, prime_total_o,
                          want.prime_total);
      end
    end
    out_stall_i <= rst_ni && idle_en && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // Zero and one (never prime), the small values 2 to 5, 97, and the largest
  // prime that fits in 16 bits and the prime just above it.
  task automatic test_edge_values();
    send_candidate(32'd0);
    send_candidate(32'd1);
    send_candidate(32'd2);
    send_candidate(32'd3);
    send_candidate(32'd4);
    send_candidate(32'd5);
    send_candidate(32'd97);
    send_candidate(32'd65521);
    send_candidate(32'd65537);
  endtask

  // Squares of primes: the divisor equal to the root has to be tried.
  task automatic test_prime_squares();
    send_candidate(32'd9);
    send_candidate(32'd25);
    send_candidate(32'd49);
    send_candidate(32'd121);
    send_candidate(32'd63001);     // 251 squared
    send_candidate(32'd16801801);  // 4099 squared, ~2k divisors
  endtask

  // Full-width values: all ones, all ones less one, top bit alone, alternating
  // bits, and the largest 32-bit prime, which runs the divisor loop to its end.
  task automatic test_wide_values();
    send_candidate(32'hFFFF_FFFF);
    send_candidate(32'h8000_0000);
    send_candidate(32'hFFFF_FFFE);
    send_candidate(32'h5555_5555);
    send_candidate(32'hFFFF_FFFB);
  endtask

  // Sender holds off until the pipe is empty, then resumes.
  task automatic test_drain_pause();
    send_candidate(32'd7);
    send_candidate(32'd8);
    wait_for_drain();
    send_candidate(32'd11);
  endtask

  // One long stretch with no idling on either channel.
  task automatic test_steady_stream();
    idle_en = 1'b0;
    repeat (RANDOM_STEADY) send_candidate(pick_candidate());
    idle_en = 1'b1;
  endtask

  // Random requests with idle gaps and result stalls.
  task automatic test_random_mix();
    repeat (RANDOM_MIXED) send_candidate(pick_candidate());
  endtask

  initial begin
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    candidate_i       = 32'd0;
    idle_en           = 1'b1;
    model_tally       = 32'd0;
    sent_count        = 0;
    error_count       = 0;
    largest_candidate = 32'd0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_edge_values();
    test_prime_squares();
    test_wide_values();
    test_drain_pause();
    test_steady_stream();
    test_random_mix();

    // Drain, then give any stray result time to show up.
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("tb: %0d requests checked, %0d primes counted, largest candidate %0d",
             sent_count, model_tally, largest_candidate);
    $display("tb: idle gaps and result stalls on both channels, plus one stall-free run");
    if (error_count == 0 && pending_verdicts.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
